// File: hw/rtl/modbus_rtu_master_frame_engine_unit_macros.svh
// Assertion macros for the Modbus RTU master frame engine
`ifndef MODBUS_RTU_MASTER_FRAME_ENGINE_UNIT_MACROS_SVH
`define MODBUS_RTU_MASTER_FRAME_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset
`define MBRTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mbrtu: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define MBRTU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mbrtu: next-cycle check failed");

`else

`define MBRTU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MBRTU_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/mbrtu_pkg.sv
package mbrtu_pkg;

	// Input item modes
	localparam logic [1:0] MODE_START_RD = 2'd0;
	localparam logic [1:0] MODE_START_WR = 2'd1;
	localparam logic [1:0] MODE_RX_BYTE  = 2'd2;
	localparam logic [1:0] MODE_RX_END   = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Pending command codes
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Function codes and CRC constants
	localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] LO_MASK         = 16'h00FF;
	localparam logic [15:0] HI_MASK         = 16'hFF00;

	localparam int FRAME_LEN = 8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  slave_addr;
		logic [15:0] reg_addr;
		logic [15:0] word_arg;
		logic [7:0]  rx_byte;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [15:0] out_value;
		logic        success;
		logic        last;
	} res_item_t;

	// One byte of the reflected Modbus CRC-16
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/modbus_rtu_master_frame_engine_unit.sv
// Start item: accepted in idle, then 8 transmit beats at one per cycle unless stalled.
// Response byte: handled on accept; a write then compares the echo with the frame memory.
// End item: a good read drains each stored word from the word memory, then the status.
// Output register lets a finished beat wait while work goes on; a stall holds it.
// Reset clears all control state; frame and word memories hold no reset value.
`include "modbus_rtu_master_frame_engine_unit_macros.svh"

module modbus_rtu_master_frame_engine_unit #(
	parameter int MAX_POINTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  mbrtu_pkg::cmd_item_t  cmd_beat,
	output logic                  res_valid,
	input  logic                  res_stall,
	output mbrtu_pkg::res_item_t  res_beat
);

	import mbrtu_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TX,
		ST_CHK,
		ST_DRAIN_RD,
		ST_DRAIN_EMIT,
		ST_STATUS
	} state_t;

	state_t          state_q;
	logic [1:0]      pending_q;
	logic [7:0]      slave_q;
	logic [7:0]      fc_q;
	logic [15:0]     addr_q;
	logic [15:0]     arg_q;
	logic [CW-1:0]   count_q;
	logic [2:0]      tx_idx_q;
	logic [15:0]     tx_crc_q;
	logic [7:0]      rx_count_q;
	logic [15:0]     crc_q;
	logic [15:0]     recv_crc_q;
	logic            bad_q;
	logic [7:0]      hold_q;
	logic [7:0]      byte_q;
	logic            ok_q;
	logic [CW-1:0]   drain_idx_q;
	logic            res_valid_q;
	res_item_t       res_q;

	// Memories
	logic [7:0]      frame_mem [FRAME_LEN];
	logic [15:0]     word_mem  [MAX_POINTS];
	logic [7:0]      frame_rd_s1;
	logic [15:0]     word_rd_s1;

	logic            accept;
	logic            slot_free;
	logic            res_load;
	logic [7:0]      tx_byte;
	logic            frame_we;
	logic [7:0]      total;
	logic [7:0]      off;
	logic            word_we;
	logic [AW-1:0]   word_waddr;
	logic            rd_ok;
	logic            wr_ok;
	logic            end_ok;
	logic            is_start;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign slot_free = !res_valid_q || !res_stall;
	assign is_start  = (cmd_beat.mode == MODE_START_RD) || (cmd_beat.mode == MODE_START_WR);

	// A new beat enters the output register in the emitting states
	assign res_load  = slot_free && ((state_q == ST_TX) || (state_q == ST_DRAIN_EMIT)
		|| (state_q == ST_STATUS));

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

	// Pick the request byte for the current transmit slot
	always_comb begin
		case (tx_idx_q)
			3'd0:    tx_byte = slave_q;
			3'd1:    tx_byte = fc_q;
			3'd2:    tx_byte = addr_q[15:8];
			3'd3:    tx_byte = addr_q[7:0];
			3'd4:    tx_byte = arg_q[15:8];
			3'd5:    tx_byte = arg_q[7:0];
			3'd6:    tx_byte = 8'(tx_crc_q & LO_MASK);
			default: tx_byte = 8'((tx_crc_q & HI_MASK) >> 8);
		endcase
	end

	assign frame_we = (state_q == ST_TX) && slot_free;

	// Read response bookkeeping
	assign total      = 8'({count_q, 1'b0}) + 8'd5;
	assign off        = rx_count_q - 8'd3;
	assign word_waddr = AW'(off[7:1]);
	assign word_we    = accept && (cmd_beat.mode == MODE_RX_BYTE) && (pending_q == CMD_READ)
		&& !bad_q && (rx_count_q >= 8'd3) && (rx_count_q < total - 8'd2) && off[0];

	assign rd_ok  = !bad_q && (rx_count_q == total) && (crc_q == recv_crc_q);
	assign wr_ok  = !bad_q && (rx_count_q == 8'd8);
	assign end_ok = (pending_q == CMD_READ) ? rd_ok : ((pending_q == CMD_WRITE) ? wr_ok : 1'b0);

	// Frame memory: write during transmit, read at the echo position
	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[tx_idx_q] <= tx_byte;
		end
		frame_rd_s1 <= frame_mem[rx_count_q[2:0]];
	end

	// Word memory: write as words complete, read at the drain position
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[word_waddr] <= {hold_q, cmd_beat.rx_byte};
		end
		word_rd_s1 <= word_mem[drain_idx_q[AW-1:0]];
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= CMD_NONE;
			slave_q     <= '0;
			fc_q        <= '0;
			addr_q      <= '0;
			arg_q       <= '0;
			count_q     <= '0;
			tx_idx_q    <= '0;
			tx_crc_q    <= CRC_INIT;
			rx_count_q  <= '0;
			crc_q       <= CRC_INIT;
			recv_crc_q  <= '0;
			bad_q       <= 1'b0;
			hold_q      <= '0;
			byte_q      <= '0;
			ok_q        <= 1'b0;
			drain_idx_q <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// load a new output beat, or drop the one just taken
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_start) begin
							// latch the request and arm the checker
							slave_q    <= cmd_beat.slave_addr;
							fc_q       <= (cmd_beat.mode == MODE_START_RD) ?
								FC_READ_HOLDING : FC_WRITE_SINGLE;
							addr_q     <= cmd_beat.reg_addr;
							arg_q      <= cmd_beat.word_arg;
							pending_q  <= (cmd_beat.mode == MODE_START_RD) ? CMD_READ : CMD_WRITE;
							count_q    <= (cmd_beat.mode == MODE_START_RD) ?
								CW'(cmd_beat.word_arg) : '0;
							bad_q      <= (cmd_beat.mode == MODE_START_RD) &&
								(cmd_beat.word_arg > 16'(MAX_POINTS));
							rx_count_q <= '0;
							crc_q      <= CRC_INIT;
							recv_crc_q <= '0;
							hold_q     <= '0;
							tx_idx_q   <= '0;
							tx_crc_q   <= CRC_INIT;
							state_q    <= ST_TX;
						end else if (cmd_beat.mode == MODE_RX_BYTE) begin
							if (pending_q == CMD_READ) begin
								if (!bad_q && (rx_count_q < total)) begin
									if ((rx_count_q == 8'd0) && (cmd_beat.rx_byte != slave_q)) begin
										bad_q <= 1'b1;
									end else if (rx_count_q < total - 8'd2) begin
										crc_q <= crc_byte(crc_q, cmd_beat.rx_byte);
										if ((rx_count_q >= 8'd3) && !off[0]) begin
											hold_q <= cmd_beat.rx_byte;
										end
									end else if (rx_count_q == total - 8'd2) begin
										recv_crc_q[7:0] <= cmd_beat.rx_byte;
									end else begin
										recv_crc_q[15:8] <= cmd_beat.rx_byte;
									end
									rx_count_q <= rx_count_q + 8'd1;
								end
							end else if (pending_q == CMD_WRITE) begin
								// compare against the sent frame next cycle
								byte_q  <= cmd_beat.rx_byte;
								state_q <= ST_CHK;
							end
						end else begin
							// response end: drain words on a good read, then status
							ok_q        <= end_ok;
							drain_idx_q <= '0;
							if ((pending_q == CMD_READ) && rd_ok && (count_q != '0)) begin
								state_q <= ST_DRAIN_RD;
							end else begin
								state_q <= ST_STATUS;
							end
						end
					end
				end
				ST_TX: begin
					if (slot_free) begin
						res_q       <= '{out_kind: KIND_TX, out_value: {8'h00, tx_byte},
							success: 1'b0, last: (tx_idx_q == 3'd7)};
						if (tx_idx_q < 3'd6) begin
							tx_crc_q <= crc_byte(tx_crc_q, tx_byte);
						end
						tx_idx_q <= tx_idx_q + 3'd1;
						if (tx_idx_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CHK: begin
					if ((rx_count_q >= 8'd8) || (byte_q != frame_rd_s1)) begin
						bad_q <= 1'b1;
					end
					if (rx_count_q < 8'd9) begin
						rx_count_q <= rx_count_q + 8'd1;
					end
					state_q <= ST_IDLE;
				end
				ST_DRAIN_RD: begin
					// wait out the memory read
					state_q <= ST_DRAIN_EMIT;
				end
				ST_DRAIN_EMIT: begin
					if (slot_free) begin
						res_q       <= '{out_kind: KIND_WORD, out_value: word_rd_s1,
							success: 1'b0, last: 1'b0};
						if (drain_idx_q == count_q - CW'(1)) begin
							state_q <= ST_STATUS;
						end else begin
							drain_idx_q <= drain_idx_q + CW'(1);
							state_q     <= ST_DRAIN_RD;
						end
					end
				end
				ST_STATUS: begin
					if (slot_free) begin
						res_q       <= '{out_kind: KIND_STATUS, out_value: 16'h0000,
							success: ok_q, last: 1'b1};
						pending_q   <= CMD_NONE;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`MBRTU_ASSERT_NXT(a_start_enters_tx, clk, arst_n, accept && is_start, state_q == ST_TX)
	`MBRTU_ASSERT_IMP(a_status_is_last, clk, arst_n, res_valid_q && (res_q.out_kind == KIND_STATUS), res_q.last)
	`MBRTU_ASSERT_IMP(a_word_only_good_read, clk, arst_n, res_valid_q && (res_q.out_kind == KIND_WORD), (pending_q == CMD_READ) && ok_q)
	`MBRTU_ASSERT_IMP(a_write_count_bound, clk, arst_n, pending_q == CMD_WRITE, rx_count_q <= 8'd9)

endmodule

// File: dv/modbus_rtu_master_frame_engine_unit_test.sv
module modbus_rtu_master_frame_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrtu_pkg::*;

	localparam int          POINT_LIMIT  = 32;
	localparam int unsigned ITEM_TARGET  = 430;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned LIMIT_CYCLES = 500000;
	localparam int unsigned IDLE_PCT     = 12;

	typedef logic [FRAME_LEN-1:0][7:0] req_frame_t;
	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		FLAW_NONE,
		FLAW_BAD_ADDR,
		FLAW_BIT_ERROR,
		FLAW_SHORT,
		FLAW_EXTRA
	} reply_flaw_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	cmd_item_t  cmd_beat;
	logic       res_valid;
	logic       res_stall;
	res_item_t  res_beat;

	// Mirror of the engine state
	logic [1:0]  pend_cmd;
	logic [7:0]  pend_slave;
	logic [15:0] pend_count;
	req_frame_t  req_frame;
	logic [7:0]  resp_idx;
	logic [15:0] resp_crc;
	logic [15:0] trailer_crc;
	logic        resp_bad;
	logic [15:0] word_buf[POINT_LIMIT];
	logic [7:0]  hi_byte;

	res_item_t   master_outputs_q[$];
	int unsigned effective_items;
	int unsigned failures;
	int unsigned idle_pct;
	int unsigned cycle_count;
	bit          backlog_request;

	modbus_rtu_master_frame_engine_unit #(
		.MAX_POINTS(POINT_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_beat (cmd_beat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_beat (res_beat)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Bit-serial reflected CRC-16, one byte at a time
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ data[k];
			r  = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// Assemble the 8-byte request with its CRC trailer, low byte first
	function automatic req_frame_t build_request(input logic [1:0] mode, input logic [7:0] slave,
			input logic [15:0] addr, input logic [15:0] arg);
		req_frame_t  f;
		logic [15:0] c;
		f[0] = slave;
		f[1] = (mode == MODE_START_RD) ? FC_READ_HOLDING : FC_WRITE_SINGLE;
		f[2] = addr[15:8];
		f[3] = addr[7:0];
		f[4] = arg[15:8];
		f[5] = arg[7:0];
		c = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			c = crc16_step(c, f[i]);
		end
		f[6] = c[7:0];
		f[7] = c[15:8];
		return f;
	endfunction

	// Advance the mirror by one beat and queue the results it causes;
	// return 0 when the beat leaves the outcome unchanged
	function automatic bit compute_master_outputs(input cmd_item_t item);
		res_item_t   r;
		int unsigned total;
		int unsigned idx;
		bit          ok;
		total = 2 * pend_count + 5;
		case (item.mode)
		MODE_START_RD, MODE_START_WR: begin
			req_frame = build_request(item.mode, item.slave_addr, item.reg_addr, item.word_arg);
			for (int i = 0; i < FRAME_LEN; i++) begin
				r.out_kind  = KIND_TX;
				r.out_value = {8'h00, req_frame[i]};
				r.success   = 1'b0;
				r.last      = (i == FRAME_LEN - 1);
				master_outputs_q.push_back(r);
			end
			pend_cmd    = (item.mode == MODE_START_RD) ? CMD_READ : CMD_WRITE;
			pend_slave  = item.slave_addr;
			pend_count  = (item.mode == MODE_START_RD) ? item.word_arg : 16'd0;
			resp_idx    = 8'd0;
			resp_crc    = CRC_INIT;
			trailer_crc = 16'd0;
			hi_byte     = 8'd0;
			resp_bad    = (item.mode == MODE_START_RD) && (item.word_arg > POINT_LIMIT);
			return 1'b1;
		end
		MODE_RX_BYTE: begin
			if (pend_cmd == CMD_READ) begin
				idx = resp_idx;
				if (resp_bad || idx >= total) begin
					return 1'b0;
				end
				if (idx == 0 && item.rx_byte != pend_slave) begin
					resp_bad = 1'b1;
				end else if (idx < total - 2) begin
					resp_crc = crc16_step(resp_crc, item.rx_byte);
					if (idx >= 3) begin
						if (((idx - 3) & 1) == 0) begin
							hi_byte = item.rx_byte;
						end else if (((idx - 3) >> 1) < POINT_LIMIT) begin
							word_buf[(idx - 3) >> 1] = {hi_byte, item.rx_byte};
						end
					end
				end else if (idx == total - 2) begin
					trailer_crc[7:0] = item.rx_byte;
				end else begin
					trailer_crc[15:8] = item.rx_byte;
				end
				resp_idx = 8'(idx + 1);
				return 1'b1;
			end else if (pend_cmd == CMD_WRITE) begin
				ok = !resp_bad;
				if (resp_idx >= FRAME_LEN || item.rx_byte != req_frame[resp_idx[2:0]]) begin
					resp_bad = 1'b1;
				end
				if (resp_idx < FRAME_LEN + 1) begin
					resp_idx = resp_idx + 8'd1;
				end
				return ok;
			end
			return 1'b0;
		end
		default: begin
			// End of response: drain words on a good read, then the status
			ok = 1'b0;
			if (pend_cmd == CMD_READ) begin
				ok = !resp_bad && resp_idx == total && resp_crc == trailer_crc;
				if (ok) begin
					for (int i = 0; i < pend_count && i < POINT_LIMIT; i++) begin
						r.out_kind  = KIND_WORD;
						r.out_value = word_buf[i];
						r.success   = 1'b0;
						r.last      = 1'b0;
						master_outputs_q.push_back(r);
					end
				end
			end else if (pend_cmd == CMD_WRITE) begin
				ok = !resp_bad && resp_idx == FRAME_LEN;
			end
			r.out_kind  = KIND_STATUS;
			r.out_value = 16'd0;
			r.success   = ok;
			r.last      = 1'b1;
			master_outputs_q.push_back(r);
			pend_cmd = CMD_NONE;
			return 1'b1;
		end
		endcase
	endfunction

	function automatic cmd_item_t start_beat(input logic [1:0] mode, input logic [7:0] slave,
			input logic [15:0] addr, input logic [15:0] arg);
		cmd_item_t c;
		c.mode       = mode;
		c.slave_addr = slave;
		c.reg_addr   = addr;
		c.word_arg   = arg;
		c.rx_byte    = 8'($urandom);
		return c;
	endfunction

	function automatic cmd_item_t byte_beat(input logic [7:0] b);
		cmd_item_t c;
		c.mode       = MODE_RX_BYTE;
		c.slave_addr = 8'($urandom);
		c.reg_addr   = 16'($urandom);
		c.word_arg   = 16'($urandom);
		c.rx_byte    = b;
		return c;
	endfunction

	function automatic cmd_item_t end_beat();
		cmd_item_t c;
		c = byte_beat(8'($urandom));
		c.mode = MODE_RX_END;
		return c;
	endfunction

	// Well-formed read response: address, function, byte count, words, CRC
	function automatic byte_q_t build_read_reply(input logic [7:0] slave, input int unsigned n);
		byte_q_t     q;
		logic [15:0] c;
		logic [15:0] w;
		q.push_back(slave);
		q.push_back(FC_READ_HOLDING);
		q.push_back(8'(2 * n));
		repeat (n) begin
			w = 16'($urandom);
			q.push_back(w[15:8]);
			q.push_back(w[7:0]);
		end
		c = CRC_INIT;
		foreach (q[i]) begin
			c = crc16_step(c, q[i]);
		end
		q.push_back(c[7:0]);
		q.push_back(c[15:8]);
		return q;
	endfunction

	function automatic byte_q_t echo_reply(input req_frame_t f);
		byte_q_t q;
		for (int i = 0; i < FRAME_LEN; i++) begin
			q.push_back(f[i]);
		end
		return q;
	endfunction

	// Offer one beat at the falling edge and hold it until taken
	task automatic send_beat(input cmd_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_beat  <= item;
		@(posedge clk);
		while (cmd_stall !== 1'b0) begin
			@(posedge clk);
		end
		if (compute_master_outputs(item)) begin
			effective_items++;
		end
	endtask

	// Damage the reply as asked, feed it byte by byte, then close it
	task automatic send_reply(input byte_q_t reply, input reply_flaw_t flaw);
		int unsigned pos;
		case (flaw)
		FLAW_BAD_ADDR: begin
			reply[0] = reply[0] ^ 8'($urandom_range(1, 255));
		end
		FLAW_BIT_ERROR: begin
			pos = $urandom_range(reply.size() - 1);
			reply[pos] = reply[pos] ^ (8'd1 << $urandom_range(7));
		end
		FLAW_SHORT: begin
			repeat ($urandom_range(1, reply.size())) void'(reply.pop_back());
		end
		FLAW_EXTRA: begin
			repeat ($urandom_range(1, 3)) reply.push_back(8'($urandom));
		end
		default: ;
		endcase
		foreach (reply[i]) begin
			send_beat(byte_beat(reply[i]));
		end
		send_beat(end_beat());
	endtask

	// Drop valid and hold off until every queued result has come back
	task automatic wait_for_drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (master_outputs_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One command with its response, mostly well formed
	task automatic run_random_sequence();
		int unsigned pick;
		int unsigned n;
		int unsigned size_roll;
		logic [7:0]  slave;
		logic [15:0] addr;
		logic [15:0] arg;
		reply_flaw_t flaw;
		cmd_item_t   noise;
		pick  = $urandom_range(99);
		slave = 8'($urandom);
		addr  = 16'($urandom);
		arg   = 16'($urandom);
		flaw  = ($urandom_range(99) < 65) ? FLAW_NONE : reply_flaw_t'($urandom_range(1, 4));
		if (pick < 8) begin
			noise.mode       = 2'($urandom);
			noise.slave_addr = slave;
			noise.reg_addr   = addr;
			noise.word_arg   = arg;
			noise.rx_byte    = 8'($urandom);
			send_beat(noise);
		end else if (pick < 55) begin
			size_roll = $urandom_range(99);
			if (size_roll < 85) begin
				n = $urandom_range(0, 4);
			end else if (size_roll < 95) begin
				n = $urandom_range(5, POINT_LIMIT);
			end else begin
				n = $urandom_range(POINT_LIMIT + 1, 65535);
			end
			send_beat(start_beat(MODE_START_RD, slave, addr, 16'(n)));
			if ($urandom_range(99) < 5) begin
				// leave it pending so the next start abandons it
			end else if (n > POINT_LIMIT) begin
				repeat ($urandom_range(0, 3)) send_beat(byte_beat(8'($urandom)));
				send_beat(end_beat());
			end else begin
				send_reply(build_read_reply(slave, n), flaw);
			end
		end else begin
			send_beat(start_beat(MODE_START_WR, slave, addr, arg));
			if ($urandom_range(99) >= 5) begin
				send_reply(echo_reply(build_request(MODE_START_WR, slave, addr, arg)), flaw);
			end
		end
	endtask

	task automatic test_nothing_pending();
		send_beat(byte_beat(8'hFF));
		send_beat(end_beat());
	endtask

	task automatic test_count_too_large();
		send_beat(start_beat(MODE_START_RD, 8'hFF, 16'hFFFF, 16'hFFFF));
		send_beat(byte_beat(8'hFF));
		send_beat(end_beat());
	endtask

	task automatic test_abandoned_start();
		send_beat(start_beat(MODE_START_WR, 8'h5A, 16'h1234, 16'hBEEF));
		send_beat(start_beat(MODE_START_RD, 8'h00, 16'h0000, 16'h0000));
		send_reply(build_read_reply(8'h00, 0), FLAW_NONE);
	endtask

	task automatic test_write_extremes();
		send_beat(start_beat(MODE_START_WR, 8'hFF, 16'hFFFF, 16'hFFFF));
		send_reply(echo_reply(build_request(MODE_START_WR, 8'hFF, 16'hFFFF, 16'hFFFF)), FLAW_NONE);
	endtask

	task automatic test_wrong_slave();
		send_beat(start_beat(MODE_START_RD, 8'h5A, 16'h1234, 16'd1));
		send_beat(byte_beat(8'hA5));
		send_beat(end_beat());
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		repeat (12) run_random_sequence();
		idle_pct = IDLE_PCT;
	endtask

	// Hold the result side off for a long stretch while commands keep coming
	task automatic test_receiver_backlog();
		logic [7:0] slave;
		backlog_request = 1'b1;
		repeat (2) begin
			slave = 8'($urandom);
			send_beat(start_beat(MODE_START_RD, slave, 16'($urandom), 16'(POINT_LIMIT)));
			send_reply(build_read_reply(slave, POINT_LIMIT), FLAW_NONE);
		end
		send_beat(start_beat(MODE_START_WR, 8'h11, 16'h2222, 16'h3333));
		send_reply(echo_reply(build_request(MODE_START_WR, 8'h11, 16'h2222, 16'h3333)), FLAW_NONE);
	endtask

	task automatic test_random_traffic();
		while (effective_items < ITEM_TARGET) begin
			run_random_sequence();
		end
	endtask

	// Drive the result stall: random idling, or a long counted hold when asked
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (backlog_request) begin
				backlog_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endfunction

	// Compare each accepted result beat with the oldest one awaited
	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (master_outputs_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual kind %0h value %0h ok %0b last %0b",
					$time, res_beat.out_kind, res_beat.out_value, res_beat.success, res_beat.last);
				failures++;
			end else begin
				want = master_outputs_q.pop_front();
				check_field("out_kind", 16'(want.out_kind), 16'(res_beat.out_kind));
				check_field("out_value", want.out_value, res_beat.out_value);
				check_field("success", 16'(want.success), 16'(res_beat.success));
				check_field("last", 16'(want.last), 16'(res_beat.last));
			end
		end
	end

	// Abandon a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[modbus_rtu_master_frame_engine_unit] ERROR");
		$finish;
	end

	initial begin
		failures        = 0;
		effective_items = 0;
		idle_pct        = IDLE_PCT;
		backlog_request = 1'b0;
		pend_cmd        = CMD_NONE;
		pend_slave      = 8'd0;
		pend_count      = 16'd0;
		resp_idx        = 8'd0;
		resp_crc        = CRC_INIT;
		trailer_crc     = 16'd0;
		resp_bad        = 1'b0;
		hi_byte         = 8'd0;
		cmd_valid       = 1'b0;
		cmd_beat        = '0;
		arst_n          = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_nothing_pending();
		wait_for_drain();
		test_count_too_large();
		wait_for_drain();
		test_abandoned_start();
		wait_for_drain();
		test_write_extremes();
		wait_for_drain();
		test_wrong_slave();
		wait_for_drain();
		test_back_to_back();
		wait_for_drain();
		test_receiver_backlog();
		wait_for_drain();
		test_random_traffic();
		wait_for_drain();

		// Let a stray late beat show up before the verdict
		repeat (200) @(posedge clk);
		if (failures == 0 && master_outputs_q.size() == 0) begin
			$display("[modbus_rtu_master_frame_engine_unit] OK");
		end else begin
			$display("[modbus_rtu_master_frame_engine_unit] ERROR");
		end
		$finish;
	end

endmodule
